// ===== rtl/hid_relay_pkg.sv =====
// Shared types and constants for the HID report hotkey relay.
// Holds the input and result beat structs, register indexes and reset values.
// No dependencies.
package hid_relay_pkg;

    // Default width of the millisecond timestamp arithmetic.
    localparam int TIME_BITS_DEFAULT = 32;

    // Configuration port shape.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MS      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWITCH_KEYCODE = 1'd1;

    // Register reset values.
    localparam logic [15:0] WINDOW_MS_RESET      = 16'd400;
    localparam logic [7:0]  SWITCH_KEYCODE_RESET = 8'h47;

    // Read lengths that carry a report.
    localparam logic [3:0] LEN_BOOT    = 4'd8;
    localparam logic [3:0] LEN_WITH_ID = 4'd9;

    // Input commands.
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_STOP   = 1'b1;

    // Frame kinds.
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Depth of the result queue.
    localparam int QUEUE_DEPTH = 4;

    // One input beat.
    typedef struct packed {
        logic        command;
        logic [3:0]  read_length;
        logic [7:0]  first_byte;
        logic [63:0] rest_bytes;
        logic [31:0] time_ms;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic        target_output;
        logic        frame_kind;
        logic [63:0] payload;
        logic        last_result;
    } out_item_t;

endpackage

// ===== rtl/hid_report_hotkey_relay.sv =====
// Top level of the HID report hotkey relay.
// Depends on hid_relay_pkg for beat types, register indexes and constants.
// Input register, single-pass decode and a small result queue.

// The relay takes one input beat per cycle, while in_stall is low, into an
// input register, decodes it there in one pass, updates the tap state and,
// as the register drains, writes up to two result beats into a four-entry
// result queue that offers them at the output. A new input is taken
// whenever the input register is free or drains, and it drains when the
// queue has room for two results. Sustained rate is one input per cycle
// while each input yields at most one result and out_stall is low; an
// input that switches outputs yields two results and takes two output
// beats, which the output side sets. A read of a length other than 8 or 9,
// or a report equal to the previous one, yields no result. Configuration
// writes take effect at once and are meant to be made while the block is idle.
module hid_report_hotkey_relay #(
    parameter int TIME_BITS = hid_relay_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  hid_relay_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output hid_relay_pkg::out_item_t               out_data,
    input  logic                                   cfg_write,
    input  logic [hid_relay_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hid_relay_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PTR_BITS = $clog2(hid_relay_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(hid_relay_pkg::QUEUE_DEPTH + 1);

    // Configuration registers.
    logic [15:0] window_ms_reg;
    logic [7:0]  switch_keycode_reg;

    // Input register.
    logic                    s1_valid_reg;
    hid_relay_pkg::in_item_t s1_data_reg;

    // Tap and routing state.
    logic [63:0]          previous_report_reg, previous_report_next;
    logic                 key_was_down_reg, key_was_down_next;
    logic                 first_tap_armed_reg, first_tap_armed_next;
    logic [TIME_BITS-1:0] first_tap_time_reg, first_tap_time_next;
    logic                 active_output_reg, active_output_next;

    // Result queue.
    hid_relay_pkg::out_item_t queue_reg [hid_relay_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]      count_reg;

    // Decode signals.
    logic                     s1_go;
    logic                     in_accept;
    logic                     out_pop;
    logic                     report_ok;
    logic [63:0]              report;
    logic [63:0]              fwd;
    logic                     down;
    logic                     press;
    logic                     switch_now;
    logic [TIME_BITS-1:0]     t_now;
    logic [TIME_BITS-1:0]     elapsed;
    logic [1:0]               push_count;
    hid_relay_pkg::out_item_t result0, result1;

    // The input register drains when the queue can take two results.
    assign s1_go     = s1_valid_reg && (count_reg <= CNT_BITS'(hid_relay_pkg::QUEUE_DEPTH - 2));
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_data  = queue_reg[rd_ptr_reg];
    assign out_pop   = out_valid && !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg      <= hid_relay_pkg::WINDOW_MS_RESET;
            switch_keycode_reg <= hid_relay_pkg::SWITCH_KEYCODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hid_relay_pkg::REG_WINDOW_MS:      window_ms_reg <= cfg_data;
                hid_relay_pkg::REG_SWITCH_KEYCODE: switch_keycode_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Build the 8-byte report from the raw read.
    always_comb
    begin
        report    = '0;
        report_ok = 1'b0;
        case (s1_data_reg.read_length)
            hid_relay_pkg::LEN_BOOT:
            begin
                report    = {s1_data_reg.rest_bytes[55:0], s1_data_reg.first_byte};
                report_ok = 1'b1;
            end
            hid_relay_pkg::LEN_WITH_ID:
            begin
                report    = s1_data_reg.rest_bytes;
                report_ok = 1'b1;
            end
            default:
            begin
                report    = '0;
                report_ok = 1'b0;
            end
        endcase
    end

    // Find and strip the switch key in key bytes 2 through 7.
    always_comb
    begin
        down = 1'b0;
        fwd  = report;
        for (int i = 2; i < 8; i++)
        begin
            if (report[i*8 +: 8] == switch_keycode_reg)
            begin
                down         = 1'b1;
                fwd[i*8 +: 8] = 8'h00;
            end
        end
    end

    // Double-tap detection on the press edge of the switch key.
    assign t_now      = TIME_BITS'(s1_data_reg.time_ms);
    assign elapsed    = t_now - first_tap_time_reg;
    assign press      = down && !key_was_down_reg;
    assign switch_now = press && first_tap_armed_reg
                        && (elapsed <= TIME_BITS'(window_ms_reg));

    // Next state and the results of the item in the input register.
    always_comb
    begin
        previous_report_next = previous_report_reg;
        key_was_down_next    = key_was_down_reg;
        first_tap_armed_next = first_tap_armed_reg;
        first_tap_time_next  = first_tap_time_reg;
        active_output_next   = active_output_reg;
        push_count           = 2'd0;
        result0              = '0;
        result1              = '0;

        if (s1_data_reg.command == hid_relay_pkg::CMD_STOP)
        begin
            // Stop sends a release to the active output and changes nothing.
            push_count            = 2'd1;
            result0.target_output = active_output_reg;
            result0.frame_kind    = hid_relay_pkg::KIND_RELEASE;
            result0.payload       = '0;
            result0.last_result   = 1'b1;
        end
        else if (report_ok && (report != previous_report_reg))
        begin
            previous_report_next = report;
            key_was_down_next    = down;
            if (press)
            begin
                if (switch_now)
                begin
                    first_tap_armed_next = 1'b0;
                    active_output_next   = !active_output_reg;
                end
                else
                begin
                    first_tap_armed_next = 1'b1;
                    first_tap_time_next  = t_now;
                end
            end

            // Forwarded frame goes to the output that is active afterward.
            result1.target_output = active_output_next;
            result1.frame_kind    = (fwd == '0) ? hid_relay_pkg::KIND_RELEASE
                                                : hid_relay_pkg::KIND_REPORT;
            result1.payload       = fwd;
            result1.last_result   = 1'b1;

            if (switch_now)
            begin
                // Release the old output first, then the frame.
                push_count            = 2'd2;
                result0.target_output = active_output_reg;
                result0.frame_kind    = hid_relay_pkg::KIND_RELEASE;
                result0.payload       = '0;
                result0.last_result   = 1'b0;
            end
            else
            begin
                push_count = 2'd1;
                result0    = result1;
            end
        end
    end

    // Tap and routing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_report_reg <= '0;
            key_was_down_reg    <= 1'b0;
            first_tap_armed_reg <= 1'b0;
            first_tap_time_reg  <= '0;
            active_output_reg   <= 1'b0;
        end
        else if (s1_go)
        begin
            previous_report_reg <= previous_report_next;
            key_was_down_reg    <= key_was_down_next;
            first_tap_armed_reg <= first_tap_armed_next;
            first_tap_time_reg  <= first_tap_time_next;
            active_output_reg   <= active_output_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (s1_go && (push_count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= result0;
        end
        if (s1_go && (push_count == 2'd2))
        begin
            queue_reg[wr_ptr_reg + PTR_BITS'(1)] <= result1;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s1_go)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(push_count);
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg
                         + (s1_go ? CNT_BITS'(push_count) : CNT_BITS'(0))
                         - (out_pop ? CNT_BITS'(1) : CNT_BITS'(0));
        end
    end

endmodule
